@@ rtl/core/rotary_encoder_button_qualifier_defines.svh @@
// Assertion macros for the rotary encoder and button qualifier.
// Each property is clocked on clk and disabled while arst_n is low.
// Defining ASSERT_OFF removes every assertion from the build.
`ifndef ROTARY_ENCODER_BUTTON_QUALIFIER_DEFINES_SVH
`define ROTARY_ENCODER_BUTTON_QUALIFIER_DEFINES_SVH

`ifndef ASSERT_OFF

`define REBQ_ASSERT_ALWAYS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define REBQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define REBQ_ASSERT_ALWAYS(lbl, ante, cons, msg)

`define REBQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/core/rebq_pkg.sv @@
// Shared types, codes and helpers of the rotary encoder and button qualifier.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package rebq_pkg;

	localparam int unsigned LOCKOUT_WIDTH_DEFAULT = 16;
	localparam int unsigned TICKS_WIDTH = 16;

	localparam logic [TICKS_WIDTH-1:0] TURN_LOCKOUT_RESET = 16'd10;
	localparam logic [TICKS_WIDTH-1:0] BUTTON_LOCKOUT_RESET = 16'd50;

	localparam logic [0:0] REG_TURN_LOCKOUT = 1'b0;
	localparam logic [0:0] REG_BUTTON_LOCKOUT = 1'b1;

	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_LEFT = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;

	typedef struct packed {
		logic [1:0] turn_dir;
		logic button_held;
		logic click;
	} rebq_result_t;

	// Lockout length saturated to the largest value a timer of the given width holds.
	function automatic logic [31:0] lockout_load(input logic [TICKS_WIDTH-1:0] ticks,
			input int unsigned width);
		logic [32:0] maxv;
		logic [32:0] v;
		maxv = (33'd1 << width) - 33'd1;
		v = {17'd0, ticks};
		return (v > maxv) ? maxv[31:0] : v[31:0];
	endfunction

endpackage

@@ rtl/core/rotary_encoder_button_qualifier.sv @@
// Rotary encoder and button qualifier: one word in, one word out, per sample tick.
// Result words are registered; a skid entry holds one word while the result stalls.
// Throughput: one sample word per cycle while sample_stall is low.
// Reset (arst_n low): detector idle, no latched turn, timers zero, lockouts 10 and 50.
// Depends on rebq_pkg, rebq_turn, rebq_button, rebq_out_skid and the defines header.
`timescale 1ns / 1ps
`include "rotary_encoder_button_qualifier_defines.svh"

module rotary_encoder_button_qualifier import rebq_pkg::*; #(
	parameter int unsigned LOCKOUT_WIDTH = LOCKOUT_WIDTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_stall,
	input logic line_a,
	input logic line_b,
	input logic button_level,
	input logic clear_turn,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [TICKS_WIDTH-1:0] cfg_data,
	output logic result_valid,
	input logic result_stall,
	output logic [1:0] turn_dir,
	output logic button_held,
	output logic click
);

	logic [TICKS_WIDTH-1:0] turn_lockout_q;
	logic [TICKS_WIDTH-1:0] button_lockout_q;
	logic accept;
	logic skid_full;
	logic [1:0] turn_dir_d;
	logic held_d;
	logic click_d;
	rebq_result_t result_d;
	rebq_result_t result_q;

	assign cfg_ready = 1'b1;
	assign sample_stall = skid_full;
	assign accept = sample_valid && !skid_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_lockout_q <= TURN_LOCKOUT_RESET;
			button_lockout_q <= BUTTON_LOCKOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TURN_LOCKOUT: begin
					turn_lockout_q <= cfg_data;
				end
				REG_BUTTON_LOCKOUT: begin
					button_lockout_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	rebq_turn #(
		.LOCKOUT_WIDTH(LOCKOUT_WIDTH)
	) u_turn (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.line_a(line_a),
		.line_b(line_b),
		.clear_turn(clear_turn),
		.lockout_ticks(turn_lockout_q),
		.turn_dir(turn_dir_d)
	);

	assign held_d = ~button_level;

	rebq_button #(
		.LOCKOUT_WIDTH(LOCKOUT_WIDTH)
	) u_button (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.held(held_d),
		.lockout_ticks(button_lockout_q),
		.click(click_d)
	);

	assign result_d = {turn_dir_d, held_d, click_d};

	rebq_out_skid u_out (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept),
		.push_data(result_d),
		.full(skid_full),
		.out_valid(result_valid),
		.out_stall(result_stall),
		.out_data(result_q)
	);

	assign turn_dir = result_q.turn_dir;
	assign button_held = result_q.button_held;
	assign click = result_q.click;

	`REBQ_ASSERT_NEXT(a_stall_keeps_result, sample_stall, result_valid, "stall without result")
	`REBQ_ASSERT_ALWAYS(a_dir_code, result_valid, turn_dir != 2'd3, "bad turn direction")
	`REBQ_ASSERT_ALWAYS(a_click_released, result_valid && click, !button_held, "click while held")
	`REBQ_ASSERT_NEXT(a_accept_gives_result, accept, result_valid, "accepted word lost")

endmodule

@@ rtl/core/rebq_turn.sv @@
// Quadrature turn detector with latched direction and turn lockout timer.
// Depends on rebq_pkg for direction codes and the lockout load helper.
`timescale 1ns / 1ps

module rebq_turn import rebq_pkg::*; #(
	parameter int unsigned LOCKOUT_WIDTH = LOCKOUT_WIDTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic line_a,
	input logic line_b,
	input logic clear_turn,
	input logic [TICKS_WIDTH-1:0] lockout_ticks,
	output logic [1:0] turn_dir
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_L_WAIT_B,
		PH_L_WAIT_A,
		PH_R_WAIT_B,
		PH_R_WAIT_A,
		PH_R_WAIT_C,
		PH_LOCKOUT
	} phase_t;

	phase_t phase_q, phase_d;
	logic [LOCKOUT_WIDTH-1:0] timer_q, timer_d;
	logic [1:0] latch_q, latch_d;
	logic [31:0] load_full;
	logic [LOCKOUT_WIDTH-1:0] load;

	assign load_full = lockout_load(lockout_ticks, LOCKOUT_WIDTH);
	assign load = load_full[LOCKOUT_WIDTH-1:0];

	// One sample may end several waits in a row, as a polling loop would.
	always_comb begin
		phase_d = phase_q;
		timer_d = timer_q;
		latch_d = latch_q;
		if (phase_q == PH_LOCKOUT) begin
			if (timer_q != '0) begin
				timer_d = timer_q - LOCKOUT_WIDTH'(1);
			end
			if (timer_d == '0) begin
				phase_d = PH_IDLE;
			end
		end else begin
			case (phase_q)
				PH_IDLE, PH_L_WAIT_B, PH_L_WAIT_A,
				PH_R_WAIT_B, PH_R_WAIT_A, PH_R_WAIT_C: begin
					phase_d = phase_q;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
			if (phase_d == PH_IDLE && !line_a) begin
				phase_d = line_b ? PH_R_WAIT_B : PH_L_WAIT_B;
			end
			if (phase_d == PH_L_WAIT_B && line_b) begin
				phase_d = PH_L_WAIT_A;
			end
			if (phase_d == PH_L_WAIT_A && line_a) begin
				latch_d = DIR_LEFT;
				timer_d = load;
				phase_d = (load != '0) ? PH_LOCKOUT : PH_IDLE;
			end
			if (phase_d == PH_R_WAIT_B && !line_b) begin
				phase_d = PH_R_WAIT_A;
			end
			if (phase_d == PH_R_WAIT_A && line_a) begin
				phase_d = PH_R_WAIT_C;
			end
			if (phase_d == PH_R_WAIT_C && line_b) begin
				latch_d = DIR_RIGHT;
				timer_d = load;
				phase_d = (load != '0) ? PH_LOCKOUT : PH_IDLE;
			end
		end
	end

	assign turn_dir = latch_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			latch_q <= DIR_NONE;
		end else if (accept) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			latch_q <= clear_turn ? DIR_NONE : latch_d;
		end
	end

endmodule

@@ rtl/core/rebq_button.sv @@
// Button click qualifier: press then release gives a click, then a lockout.
// Depends on rebq_pkg for the lockout load helper.
`timescale 1ns / 1ps

module rebq_button import rebq_pkg::*; #(
	parameter int unsigned LOCKOUT_WIDTH = LOCKOUT_WIDTH_DEFAULT
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic held,
	input logic [TICKS_WIDTH-1:0] lockout_ticks,
	output logic click
);

	logic [LOCKOUT_WIDTH-1:0] timer_q, timer_d;
	logic pressed_q, pressed_d;
	logic [31:0] load_full;

	assign load_full = lockout_load(lockout_ticks, LOCKOUT_WIDTH);

	always_comb begin
		timer_d = timer_q;
		pressed_d = pressed_q;
		click = 1'b0;
		if (timer_q != '0) begin
			timer_d = timer_q - LOCKOUT_WIDTH'(1);
		end else if (held && !pressed_q) begin
			pressed_d = 1'b1;
		end else if (!held && pressed_q) begin
			pressed_d = 1'b0;
			timer_d = load_full[LOCKOUT_WIDTH-1:0];
			click = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q <= '0;
			pressed_q <= 1'b0;
		end else if (accept) begin
			timer_q <= timer_d;
			pressed_q <= pressed_d;
		end
	end

endmodule

@@ rtl/core/rebq_out_skid.sv @@
// Result register with one skid entry, so the sample side stalls on a registered flag.
// Depends on rebq_pkg for the result word type.
`timescale 1ns / 1ps

module rebq_out_skid import rebq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input rebq_result_t push_data,
	output logic full,
	output logic out_valid,
	input logic out_stall,
	output rebq_result_t out_data
);

	logic main_valid_q;
	logic skid_valid_q;
	rebq_result_t main_q;
	rebq_result_t skid_q;
	logic pop;

	assign pop = main_valid_q && !out_stall;
	assign full = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else if (!push) begin
					main_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (!main_valid_q) begin
					main_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			if (!main_valid_q) begin
				main_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

endmodule

@@ verif/rotary_encoder_button_qualifier_test.sv @@
// Self-checking testbench for rotary_encoder_button_qualifier: drives sample words and register
// writes, predicts every result word and compares it field by field. Depends on rebq_pkg and the RTL.
`timescale 1ns / 1ps

module rotary_encoder_button_qualifier_test;
	import rebq_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned IDLE_PERCENT = 26;
	// Encoder levels {a, b} around one detent; stepping up turns left, stepping down turns right.
	localparam logic [7:0] DETENT_CODES = 8'b01_00_10_11;

	typedef enum logic [2:0] {
		DET_IDLE,
		DET_L_WAIT_B,
		DET_L_WAIT_A,
		DET_R_WAIT_B,
		DET_R_WAIT_A,
		DET_R_WAIT_C,
		DET_LOCKOUT
	} detent_phase_t;

	typedef struct packed {
		logic line_a;
		logic line_b;
		logic button_level;
		logic clear_turn;
	} sample_t;

	typedef struct packed {
		logic [0:0] index;
		logic [TICKS_WIDTH-1:0] data;
	} reg_write_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic line_a = 1'b1;
	logic line_b = 1'b1;
	logic button_level = 1'b1;
	logic clear_turn = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = REG_TURN_LOCKOUT;
	logic [TICKS_WIDTH-1:0] cfg_data = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [1:0] turn_dir;
	logic button_held;
	logic click;

	sample_t pending_samples[$];
	reg_write_t pending_writes[$];
	rebq_result_t expected_words[$];

	logic quiet = 1'b0;
	int unsigned failures = 0;
	int unsigned cycle_count = 0;
	int unsigned words_sent = 0;
	int unsigned words_seen = 0;
	int unsigned writes_done = 0;

	logic [TICKS_WIDTH-1:0] turn_lockout = TURN_LOCKOUT_RESET;
	logic [TICKS_WIDTH-1:0] button_lockout = BUTTON_LOCKOUT_RESET;
	detent_phase_t det_phase = DET_IDLE;
	logic [1:0] turn_latched = DIR_NONE;
	logic btn_pressed = 1'b0;
	logic [TICKS_WIDTH-1:0] det_timer = '0;
	logic [TICKS_WIDTH-1:0] btn_timer = '0;

	logic [1:0] enc_pos = 2'd0;
	logic spin_left = 1'b1;
	logic btn_level_gen = 1'b1;

	rotary_encoder_button_qualifier DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.line_a(line_a),
		.line_b(line_b),
		.button_level(button_level),
		.clear_turn(clear_turn),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.turn_dir(turn_dir),
		.button_held(button_held),
		.click(click)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic qualify_sample(input sample_t s);
		rebq_result_t w;
		logic pressed;
		logic [1:0] finished;
		pressed = ~s.button_level;
		finished = DIR_NONE;
		w.click = 1'b0;
		if (det_phase == DET_LOCKOUT) begin
			if (det_timer != 0)
				det_timer = det_timer - 1'b1;
			if (det_timer == 0)
				det_phase = DET_IDLE;
		end else begin
			if (det_phase == DET_IDLE && !s.line_a)
				det_phase = s.line_b ? DET_R_WAIT_B : DET_L_WAIT_B;
			if (det_phase == DET_L_WAIT_B && s.line_b)
				det_phase = DET_L_WAIT_A;
			if (det_phase == DET_L_WAIT_A && s.line_a)
				finished = DIR_LEFT;
			if (det_phase == DET_R_WAIT_B && !s.line_b)
				det_phase = DET_R_WAIT_A;
			if (det_phase == DET_R_WAIT_A && s.line_a)
				det_phase = DET_R_WAIT_C;
			if (det_phase == DET_R_WAIT_C && s.line_b)
				finished = DIR_RIGHT;
			if (finished != DIR_NONE) begin
				turn_latched = finished;
				det_timer = turn_lockout;
				det_phase = (turn_lockout != 0) ? DET_LOCKOUT : DET_IDLE;
			end
		end
		if (btn_timer != 0) begin
			btn_timer = btn_timer - 1'b1;
		end else if (pressed && !btn_pressed) begin
			btn_pressed = 1'b1;
		end else if (!pressed && btn_pressed) begin
			btn_pressed = 1'b0;
			btn_timer = button_lockout;
			w.click = 1'b1;
		end
		w.turn_dir = turn_latched;
		w.button_held = pressed;
		if (s.clear_turn)
			turn_latched = DIR_NONE;
		expected_words.push_back(w);
	endtask

	always @(posedge clk) begin : sample_driver
		sample_t s;
		if (!arst_n) begin
			sample_valid <= 1'b0;
		end else begin
			if (sample_valid && !sample_stall)
				qualify_sample({line_a, line_b, button_level, clear_turn});
			if (!sample_valid || !sample_stall) begin
				if (pending_samples.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PERCENT)) begin
					s = pending_samples.pop_front();
					words_sent++;
					sample_valid <= 1'b1;
					line_a <= s.line_a;
					line_b <= s.line_b;
					button_level <= s.button_level;
					clear_turn <= s.clear_turn;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : cfg_driver
		reg_write_t w;
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TURN_LOCKOUT: turn_lockout = cfg_data;
					REG_BUTTON_LOCKOUT: button_lockout = cfg_data;
					default: ;
				endcase
				writes_done++;
			end
			if (!cfg_valid || cfg_ready) begin
				if (pending_writes.size() != 0) begin
					w = pending_writes.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= w.index;
					cfg_data <= w.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		rebq_result_t w;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				words_seen++;
				if (expected_words.size() == 0) begin
					$error("unexpected result word: turn_dir %0d, button_held %0d, click %0d",
						turn_dir, button_held, click);
					failures++;
				end else begin
					w = expected_words.pop_front();
					if (turn_dir !== w.turn_dir) begin
						$error("turn_dir: expected %0d, actual %0d", w.turn_dir, turn_dir);
						failures++;
					end
					if (button_held !== w.button_held) begin
						$error("button_held: expected %0d, actual %0d", w.button_held, button_held);
						failures++;
					end
					if (click !== w.click) begin
						$error("click: expected %0d, actual %0d", w.click, click);
						failures++;
					end
				end
			end
			result_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("rotary_encoder_button_qualifier_test NOT OK");
			$finish;
		end
	end

	task automatic queue_sample(input logic a, input logic b, input logic btn, input logic clr);
		pending_samples.push_back({a, b, btn, clr});
	endtask

	task automatic wait_drained();
		while (pending_samples.size() != 0 || words_seen != words_sent)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_lockouts(input logic [TICKS_WIDTH-1:0] turn_ticks,
			input logic [TICKS_WIDTH-1:0] button_ticks);
		int unsigned writes_target;
		writes_target = writes_done + 2;
		pending_writes.push_back({REG_TURN_LOCKOUT, turn_ticks});
		pending_writes.push_back({REG_BUTTON_LOCKOUT, button_ticks});
		while (writes_done != writes_target)
			@(posedge clk);
	endtask

	// Mostly clean detents in a wandering direction, with some line noise mixed in.
	task automatic queue_random(input int count);
		int k;
		int hold;
		logic [1:0] lines;
		hold = 0;
		lines = DETENT_CODES[2*enc_pos +: 2];
		for (k = 0; k < count; k++) begin
			if (hold == 0) begin
				if ($urandom_range(99) < 12) begin
					lines = 2'($urandom_range(3));
				end else begin
					if ($urandom_range(99) < 10)
						spin_left = ~spin_left;
					enc_pos = spin_left ? enc_pos + 2'd1 : enc_pos - 2'd1;
					lines = DETENT_CODES[2*enc_pos +: 2];
				end
				hold = $urandom_range(1, 3);
			end
			hold--;
			if ($urandom_range(99) < 20)
				btn_level_gen = ~btn_level_gen;
			queue_sample(lines[1], lines[0], btn_level_gen, $urandom_range(99) < 25);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Left detent finished on one sample while the button goes down, clear, then release.
		queue_sample(1'b1, 1'b1, 1'b1, 1'b0);
		queue_sample(1'b0, 1'b0, 1'b1, 1'b0);
		queue_sample(1'b1, 1'b1, 1'b0, 1'b0);
		queue_sample(1'b1, 1'b1, 1'b0, 1'b1);
		queue_sample(1'b1, 1'b1, 1'b1, 1'b1);
		// Encoder and button activity inside both lockouts is ignored.
		queue_sample(1'b0, 1'b1, 1'b0, 1'b0);
		queue_sample(1'b0, 1'b0, 1'b1, 1'b0);
		queue_sample(1'b1, 1'b0, 1'b0, 1'b1);
		queue_sample(1'b0, 1'b0, 1'b0, 1'b0);
		queue_sample(1'b0, 1'b1, 1'b1, 1'b0);
		queue_sample(1'b1, 1'b1, 1'b0, 1'b0);
		queue_sample(1'b1, 1'b0, 1'b1, 1'b0);
		queue_sample(1'b1, 1'b1, 1'b1, 1'b0);
		// Full right detent, latched after the earlier clears.
		queue_sample(1'b0, 1'b1, 1'b0, 1'b0);
		queue_sample(1'b0, 1'b0, 1'b0, 1'b0);
		queue_sample(1'b1, 1'b0, 1'b0, 1'b0);
		queue_sample(1'b1, 1'b1, 1'b0, 1'b0);
		wait_drained();

		write_lockouts(16'd0, 16'd0);
		queue_sample(1'b0, 1'b0, 1'b0, 1'b0);
		queue_sample(1'b1, 1'b1, 1'b1, 1'b0);
		queue_sample(1'b0, 1'b1, 1'b0, 1'b0);
		queue_sample(1'b1, 1'b0, 1'b1, 1'b0);
		queue_sample(1'b1, 1'b1, 1'b0, 1'b1);
		queue_sample(1'b1, 1'b1, 1'b1, 1'b1);
		queue_random(250);
		wait_drained();

		write_lockouts(16'd1, 16'd1);
		queue_random(200);
		wait_drained();

		quiet = 1'b1;
		write_lockouts(16'd3, 16'd5);
		queue_random(250);
		wait_drained();
		quiet = 1'b0;

		write_lockouts(TICKS_WIDTH'($urandom_range(0, 20)), TICKS_WIDTH'($urandom_range(0, 20)));
		queue_random(110);
		wait_drained();
		queue_random(110);
		wait_drained();

		write_lockouts(TICKS_WIDTH'($urandom_range(0, 20)), TICKS_WIDTH'($urandom_range(0, 20)));
		queue_random(220);
		wait_drained();

		write_lockouts(16'd0, 16'hFFFF);
		queue_random(90);
		wait_drained();

		write_lockouts(16'hFFFF, 16'hFFFF);
		queue_random(90);
		wait_drained();

		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("rotary_encoder_button_qualifier_test OK");
		else
			$display("rotary_encoder_button_qualifier_test NOT OK");
		$finish;
	end

endmodule
